/* hw/rtl/p2hsv_pkg.sv */
// shared types and constants of the polarization to hsv color mapper
// no dependencies

package p2hsv_pkg;

   localparam int DEGREE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [BYTE_W-1:0] FULL_VALUE = 8'd255;

   // register index, taken from paddr above the byte offset
   localparam logic CSR_IDX_FULL_SAT = 1'b0;

   // hue sectors of 60 degrees each
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

/* hw/rtl/p2hsv_req_if.sv */
// valid/ready channel interfaces for pixel requests and color responses
// depends on p2hsv_pkg

interface p2hsv_req_if
   import p2hsv_pkg::*;
#(
   parameter int ANGLE_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [ANGLE_BITS-1:0] angle_q;
   logic        [DEGREE_W-1:0]  degree_q;

   modport source (output valid, output angle_q, output degree_q, input ready);
   modport sink   (input valid, input angle_q, input degree_q, output ready);
endinterface

interface p2hsv_rsp_if
   import p2hsv_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_first;
   logic [BYTE_W-1:0] byte_second;
   logic [BYTE_W-1:0] byte_third;

   modport source (output valid, output byte_first, output byte_second, output byte_third,
                   input ready);
   modport sink   (input valid, input byte_first, input byte_second, input byte_third,
                   output ready);
endinterface

/* hw/rtl/polarization_to_hsv_color.sv */
// polarization angle and degree to rgb bytes through the six-sector hsv rule
// depends on p2hsv_pkg and the channel interfaces in p2hsv_req_if.sv
// throughput: one transaction per cycle unless the response side stalls, set by
// the three-stage pipeline (sector and chroma, chroma times triangle
// product, rounding and channel select)
// reset: synchronous, clears the stage valid bits and full_saturation

module polarization_to_hsv_color
   import p2hsv_pkg::*;
#(
   parameter int ANGLE_BITS       = 16,
   parameter int DEGREE_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   p2hsv_req_if.sink             req_ch,
   p2hsv_rsp_if.source           rsp_ch
);

   localparam int HALF_W = ANGLE_BITS - 1;
   localparam int SIX_W  = ANGLE_BITS + 2;
   localparam int DEG_W  = DEGREE_W + 1;
   localparam int PROD_W = BYTE_W + ANGLE_BITS;
   localparam logic [DEG_W-1:0]      DEG_ONE   = DEG_W'(1) << DEGREE_FRAC_BITS;
   localparam logic [DEG_W+BYTE_W-1:0] DEG_HALF = (DEG_W+BYTE_W)'(1) << (DEGREE_FRAC_BITS - 1);
   localparam logic [PROD_W-1:0]     ANG_HALF  = PROD_W'(1) << (ANGLE_BITS - 2);

   // configuration register
   logic full_sat_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_sat_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CSR_ADDR_W-1] == CSR_IDX_FULL_SAT) begin
         full_sat_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_FULL_SAT) begin
         csr_prdata[0] = full_sat_ff;
      end
   end

   // stage handshake: a stage takes new data when empty or when it moves on
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;

   assign ready3       = !v3_ff || rsp_ch.ready;
   assign ready2       = !v2_ff || ready3;
   assign ready1       = !v1_ff || ready2;
   assign req_ch.ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_ch.valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // stage 1: fold angle, sector, triangle weight, chroma
   logic [HALF_W-1:0]       fold_a;
   logic [SIX_W-1:0]        six_a;
   logic [2:0]              sector_raw;
   logic [ANGLE_BITS-1:0]   r_mod;
   logic [DEG_W-1:0]        deg_ext;
   logic [DEG_W-1:0]        deg_clamp;
   logic [DEG_W+BYTE_W-1:0] deg_scaled;
   logic [2:0]              sector_in;
   logic [ANGLE_BITS-1:0]   tri_in;
   logic [BYTE_W-1:0]       chroma_in;
   logic [2:0]              sector1_ff;
   logic [ANGLE_BITS-1:0]   tri1_ff;
   logic [BYTE_W-1:0]       chroma1_ff;

   always_comb begin
      fold_a     = req_ch.angle_q[HALF_W-1:0];
      six_a      = {1'b0, fold_a, 2'b00} + {2'b00, fold_a, 1'b0};
      sector_raw = six_a[SIX_W-1:HALF_W];
      // exact boundary goes to the lower sector
      if (sector_raw != 3'd0 && six_a[HALF_W-1:0] == '0) begin
         sector_in = sector_raw - 3'd1;
      end else begin
         sector_in = sector_raw;
      end
      r_mod  = six_a[ANGLE_BITS-1:0];
      // M - |r - M| is r below M and 2M - r from M up
      tri_in = r_mod[ANGLE_BITS-1] ? (~r_mod + ANGLE_BITS'(1)) : r_mod;

      deg_ext    = {1'b0, req_ch.degree_q};
      deg_clamp  = (deg_ext > DEG_ONE) ? DEG_ONE : deg_ext;
      deg_scaled = ({deg_clamp, 8'h00} - {8'h00, deg_clamp}) + DEG_HALF;
      chroma_in  = full_sat_ff ? FULL_VALUE
                               : deg_scaled[DEGREE_FRAC_BITS +: BYTE_W];
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         sector1_ff <= sector_in;
         tri1_ff    <= tri_in;
         chroma1_ff <= chroma_in;
      end
   end

   // stage 2: chroma times triangle weight
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod2_ff;
   logic [2:0]        sector2_ff;
   logic [BYTE_W-1:0] chroma2_ff;

   assign prod_in = PROD_W'(chroma1_ff) * PROD_W'(tri1_ff);

   always_ff @(posedge clock) begin
      if (ready2) begin
         prod2_ff   <= prod_in;
         sector2_ff <= sector1_ff;
         chroma2_ff <= chroma1_ff;
      end
   end

   // stage 3: round x, form lo and mid, pick channels
   logic [PROD_W-1:0] prod_round;
   logic [BYTE_W:0]   x_wide;
   logic [BYTE_W-1:0] x_val;
   logic [BYTE_W-1:0] lo_val;
   logic [BYTE_W-1:0] mid_val;
   logic [BYTE_W-1:0] first_in, second_in, third_in;
   logic [BYTE_W-1:0] first_ff, second_ff, third_ff;

   always_comb begin
      prod_round = prod2_ff + ANG_HALF;
      x_wide     = prod_round[HALF_W +: BYTE_W+1];
      x_val      = (x_wide > {1'b0, chroma2_ff}) ? chroma2_ff : x_wide[BYTE_W-1:0];
      lo_val     = FULL_VALUE - chroma2_ff;
      mid_val    = x_val + lo_val;
      unique case (sector_type'(sector2_ff))
         SECTOR_RED_YELLOW: begin
            first_in = FULL_VALUE; second_in = mid_val;    third_in = lo_val;
         end
         SECTOR_YELLOW_GREEN: begin
            first_in = mid_val;    second_in = FULL_VALUE; third_in = lo_val;
         end
         SECTOR_GREEN_CYAN: begin
            first_in = lo_val;     second_in = FULL_VALUE; third_in = mid_val;
         end
         SECTOR_CYAN_BLUE: begin
            first_in = lo_val;     second_in = mid_val;    third_in = FULL_VALUE;
         end
         SECTOR_BLUE_MAGENTA: begin
            first_in = mid_val;    second_in = lo_val;     third_in = FULL_VALUE;
         end
         default: begin
            first_in = FULL_VALUE; second_in = lo_val;     third_in = mid_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
      end
   end

   assign rsp_ch.valid       = v3_ff;
   assign rsp_ch.byte_first  = first_ff;
   assign rsp_ch.byte_second = second_ff;
   assign rsp_ch.byte_third  = third_ff;

endmodule

/* hw/rtl/p2hsv_check.sv */
// port-level checks of the polarization to hsv color mapper
// depends on p2hsv_pkg; bound to polarization_to_hsv_color below

module p2hsv_check
   import p2hsv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] byte_first,
   input logic [BYTE_W-1:0] byte_second,
   input logic [BYTE_W-1:0] byte_third
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // value is full scale, so the largest channel is always 255
   a_max_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (byte_first == FULL_VALUE || byte_second == FULL_VALUE ||
                     byte_third == FULL_VALUE))
      else $error("no channel at full value");

   // an accepted transaction reaches the output when the sink keeps taking
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("transaction did not arrive after three cycles");

endmodule

bind polarization_to_hsv_color p2hsv_check u_p2hsv_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .byte_first  (rsp_ch.byte_first),
   .byte_second (rsp_ch.byte_second),
   .byte_third  (rsp_ch.byte_third)
);
